// ===== rtl/psbqf_pkg.sv =====
// ----------------------------------------------------------------------------
// psbqf_pkg
// Shared types and constants of the per-source byte quota filter.
// ----------------------------------------------------------------------------
package psbqf_pkg;

    localparam int DEF_TABLE_ENTRIES = 1024;
    localparam int DEF_COUNT_BITS    = 48;

    localparam logic [15:0] IPV4_TYPE    = 16'h0800;
    localparam logic [15:0] ETH_HDR_LEN  = 16'd14;
    localparam logic [15:0] MIN_IPV4_LEN = 16'd42;
    localparam logic [47:0] QUOTA_RESET  = 48'd100000000;

    localparam int TOTAL_BITS = 48;

    // register byte addresses
    localparam logic [0:0] REG_QUOTA = 1'b0;

    typedef enum logic [2:0] {
        CAUSE_NOT_IPV4 = 3'd0,
        CAUSE_COUNTED  = 3'd1,
        CAUSE_SHORT    = 3'd2,
        CAUSE_FULL     = 3'd3,
        CAUSE_OVER     = 3'd4
    } cause_t;

    typedef enum logic [1:0] {
        KIND_NOT_IPV4,
        KIND_SHORT,
        KIND_LOOKUP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] frame_length;
        logic [31:0] source_address;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MISS,
        ST_UPDATE
    } back_state_t;

endpackage

// ===== rtl/per_source_byte_quota_filter.sv =====
// ----------------------------------------------------------------------------
// per_source_byte_quota_filter
// Top level: stream ports, quota register, front, queue and back.
// ----------------------------------------------------------------------------
// A descriptor that needs no table lookup (short frame or not IPv4) passes
// through a queue slot into the result register. An IPv4 descriptor walks
// the source table one entry per cycle through the table RAM read port until
// it finds a match or reaches the last filled entry; on a miss it is inserted
// if there is room. A two-entry queue lets new items be taken while the table
// walk is busy and while a result waits on m_tready.
module per_source_byte_quota_filter
    import psbqf_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // ether_type, frame_length, source_address
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // verdict, cause, source_total, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [47:0] quota_reg;
    logic        push, q_full, q_valid, pop;
    job_t        push_job, q_head;
    logic        verdict;
    cause_t      cause;
    logic [47:0] source_total;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quota_reg <= QUOTA_RESET;
        end else if (psel && penable && pwrite && paddr == REG_QUOTA) begin
            quota_reg <= pwdata[47:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_QUOTA) ? {16'd0, quota_reg} : 64'd0;

    psbqf_front u_front (
        .s_valid        (s_tvalid),
        .s_ready        (s_tready),
        .ether_type     (s_tdata[15:0]),
        .frame_length   (s_tdata[31:16]),
        .source_address (s_tdata[63:32]),
        .push           (push),
        .push_job       (push_job),
        .q_full         (q_full)
    );

    psbqf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    psbqf_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (pop),
        .quota_limit  (quota_reg),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .verdict      (verdict),
        .cause        (cause),
        .source_total (source_total)
    );

    assign m_tdata = {4'd0, source_total, cause, verdict};

endmodule

// ===== rtl/psbqf_ram.sv =====
// ----------------------------------------------------------------------------
// psbqf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psbqf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/psbqf_front.sv =====
// ----------------------------------------------------------------------------
// psbqf_front
// Accepts descriptors and sorts them into direct verdicts or table lookups.
// ----------------------------------------------------------------------------
module psbqf_front
    import psbqf_pkg::*;
(
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] ether_type,
    input  logic [15:0] frame_length,
    input  logic [31:0] source_address,
    output logic        push,
    output job_t        push_job,
    input  logic        q_full
);

    kind_t kind;

    always_comb begin
        if (frame_length < ETH_HDR_LEN) begin
            kind = KIND_SHORT;
        end else if (ether_type != IPV4_TYPE) begin
            kind = KIND_NOT_IPV4;
        end else if (frame_length < MIN_IPV4_LEN) begin
            kind = KIND_SHORT;
        end else begin
            kind = KIND_LOOKUP;
        end
    end

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    assign push_job.kind           = kind;
    assign push_job.frame_length   = frame_length;
    assign push_job.source_address = source_address;

endmodule

// ===== rtl/psbqf_queue.sv =====
// ----------------------------------------------------------------------------
// psbqf_queue
// Two-entry queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module psbqf_queue
    import psbqf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic valid,
    output job_t head
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign full  = count_reg == 2'd2;
    assign valid = count_reg != 2'd0;
    assign head  = slot_reg[rd_ptr_reg];

endmodule

// ===== rtl/psbqf_back.sv =====
// ----------------------------------------------------------------------------
// psbqf_back
// Table search, insertion, quota check and counter update; holds the result.
// ----------------------------------------------------------------------------
module psbqf_back
    import psbqf_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  job_t        q_head,
    output logic        pop,
    input  logic [47:0] quota_limit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        verdict,
    output cause_t      cause,
    output logic [47:0] source_total
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UW = $clog2(TABLE_ENTRIES + 1);
    localparam int CW = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;
    localparam int MW = 32 + COUNT_BITS;

    back_state_t           state_reg, state_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [UW-1:0]         used_reg, used_next;
    logic [31:0]           key_reg, key_next;
    logic [15:0]           len_reg, len_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  verdict_reg, verdict_next;
    cause_t                cause_reg, cause_next;
    logic [47:0]           total_reg, total_next;

    logic                  wr_en;
    logic [IW-1:0]         rd_addr;
    logic [MW-1:0]         rd_data;
    logic [31:0]           rd_key;
    logic [COUNT_BITS-1:0] rd_bytes;
    logic [COUNT_BITS:0]   sum_wide;
    logic [COUNT_BITS-1:0] sum_sat;
    logic [UW-1:0]         idx_plus;
    logic                  out_free;
    logic [CW-1:0]         cnt_ext;
    logic [CW-1:0]         sum_ext;

    assign rd_key   = rd_data[MW-1:COUNT_BITS];
    assign rd_bytes = rd_data[COUNT_BITS-1:0];
    assign idx_plus = UW'(idx_reg) + UW'(1);
    assign out_free = !out_valid_reg || m_ready;
    assign sum_wide = {1'b0, cnt_reg} + (COUNT_BITS + 1)'(len_reg);
    assign sum_sat  = sum_wide[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum_wide[COUNT_BITS-1:0];
    assign cnt_ext  = CW'(cnt_reg);
    assign sum_ext  = CW'(sum_sat);

    psbqf_ram #(
        .WIDTH (MW),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data ({key_reg, sum_sat}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        verdict_next   = verdict_reg;
        cause_next     = cause_reg;
        total_next     = total_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        rd_addr        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    pop      = 1'b1;
                    key_next = q_head.source_address;
                    len_next = q_head.frame_length;
                    idx_next = '0;
                    unique case (q_head.kind)
                        KIND_NOT_IPV4: begin
                            out_valid_next = 1'b1;
                            verdict_next   = 1'b0;
                            cause_next     = CAUSE_NOT_IPV4;
                            total_next     = '0;
                        end
                        KIND_SHORT: begin
                            out_valid_next = 1'b1;
                            verdict_next   = 1'b1;
                            cause_next     = CAUSE_SHORT;
                            total_next     = '0;
                        end
                        default: begin
                            state_next = (used_reg == '0) ? ST_MISS : ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // rd_data holds entry idx_reg, next entry is fetched meanwhile
                rd_addr = idx_plus[IW-1:0];
                if (rd_key == key_reg) begin
                    cnt_next   = rd_bytes;
                    state_next = ST_UPDATE;
                end else if (idx_plus == used_reg) begin
                    state_next = ST_MISS;
                end else begin
                    idx_next = idx_plus[IW-1:0];
                end
            end
            ST_MISS: begin
                if (used_reg == UW'(TABLE_ENTRIES)) begin
                    out_valid_next = 1'b1;
                    verdict_next   = 1'b1;
                    cause_next     = CAUSE_FULL;
                    total_next     = '0;
                    state_next     = ST_IDLE;
                end else begin
                    idx_next   = used_reg[IW-1:0];
                    cnt_next   = '0;
                    used_next  = used_reg + UW'(1);
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
                if (cnt_ext > CW'(quota_limit)) begin
                    verdict_next = 1'b1;
                    cause_next   = CAUSE_OVER;
                    total_next   = cnt_ext[47:0];
                end else begin
                    wr_en        = 1'b1;
                    verdict_next = 1'b0;
                    cause_next   = CAUSE_COUNTED;
                    total_next   = sum_ext[47:0];
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        len_reg     <= len_next;
        cnt_reg     <= cnt_next;
        verdict_reg <= verdict_next;
        cause_reg   <= cause_next;
        total_reg   <= total_next;
    end

    assign m_valid      = out_valid_reg;
    assign verdict      = verdict_reg;
    assign cause        = cause_reg;
    assign source_total = total_reg;

endmodule

// ===== rtl/psbqf_checker.sv =====
// ----------------------------------------------------------------------------
// psbqf_checker
// Port-level checks of the quota filter, bound to the top level.
// ----------------------------------------------------------------------------
module psbqf_checker
    import psbqf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // drop causes and only those set the verdict bit
    a_verdict_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] == (m_tdata[3:1] == CAUSE_SHORT ||
                                    m_tdata[3:1] == CAUSE_FULL ||
                                    m_tdata[3:1] == CAUSE_OVER))
        else $error("verdict does not match cause");

    // no lookup or a full table means no byte count
    a_total_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:1] == CAUSE_NOT_IPV4 || m_tdata[3:1] == CAUSE_SHORT ||
                     m_tdata[3:1] == CAUSE_FULL) |-> m_tdata[51:4] == 48'd0)
        else $error("nonzero total without lookup");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind per_source_byte_quota_filter psbqf_checker u_psbqf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
